// File: hw/rtl/stps_pkg.sv
// Shared constants, sideband type and helper functions for the plate selector.
// No dependencies; every other file of the block imports this package.
package stps_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int MAX_PLATES   = 8;
    localparam int POS_W        = 24;
    localparam int CORDIC_STEPS = 31;
    localparam int CORDIC_FRAC  = 30;
    localparam int CORDIC_W     = POS_W + CORDIC_FRAC + 3;
    localparam int Z_W          = 32;
    localparam int PLATE_W      = $clog2(MAX_PLATES + 1);
    localparam int JUMP_W       = 14;
    localparam int RATE_W       = 15;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] head;
        logic [PLATE_W-1:0]    plates;
        logic                  lead_en;
        logic                  lead_neg;
        logic                  origin;
    } t_side;

    function automatic logic [ANGLE_BITS-1:0] scale16(input logic [15:0] v);
        logic [ANGLE_BITS+15:0] t;
        t = {v, {ANGLE_BITS{1'b0}}};
        return t[ANGLE_BITS+15:16];
    endfunction

    function automatic logic [Z_W-1:0] atan_step(input int i);
        logic [Z_W-1:0] a;
        case (i)
            0:       a = 32'd536870912;
            1:       a = 32'd316933406;
            2:       a = 32'd167458907;
            3:       a = 32'd85004756;
            4:       a = 32'd42667331;
            5:       a = 32'd21354465;
            6:       a = 32'd10679838;
            7:       a = 32'd5340245;
            8:       a = 32'd2670163;
            9:       a = 32'd1335087;
            10:      a = 32'd667544;
            11:      a = 32'd333772;
            12:      a = 32'd166886;
            13:      a = 32'd83443;
            14:      a = 32'd41722;
            15:      a = 32'd20861;
            16:      a = 32'd10430;
            17:      a = 32'd5215;
            18:      a = 32'd2608;
            19:      a = 32'd1304;
            20:      a = 32'd652;
            21:      a = 32'd326;
            22:      a = 32'd163;
            23:      a = 32'd81;
            24:      a = 32'd41;
            25:      a = 32'd20;
            26:      a = 32'd10;
            27:      a = 32'd5;
            28:      a = 32'd3;
            29:      a = 32'd1;
            30:      a = 32'd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// File: hw/rtl/stps_front.sv
// Input stage: half-plane fold of the centre vector, lead decision, plate count clamp.
// Depends on stps_pkg; feeds stps_cordic.
module stps_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic                                 i_valid,
    input  logic signed [stps_pkg::POS_W-1:0]    i_center_x,
    input  logic signed [stps_pkg::POS_W-1:0]    i_center_y,
    input  logic [15:0]                          i_spin_heading,
    input  logic signed [15:0]                   i_spin_rate,
    input  logic [3:0]                           i_plate_count,
    input  logic [stps_pkg::RATE_W-1:0]          i_min_rate,
    output logic                                 o_valid,
    output logic signed [stps_pkg::CORDIC_W-1:0] o_x,
    output logic signed [stps_pkg::CORDIC_W-1:0] o_y,
    output logic [stps_pkg::Z_W-1:0]             o_z,
    output stps_pkg::t_side                      o_side
);
    import stps_pkg::*;

    logic signed [CORDIC_W-1:0] x_s, y_s, x0, y0;
    logic [Z_W-1:0]             z0;
    logic [15:0]                mag;
    logic [PLATE_W-1:0]         plates;
    t_side                      side;

    logic                       r_valid;
    logic signed [CORDIC_W-1:0] r_x, r_y;
    logic [Z_W-1:0]             r_z;
    t_side                      r_side;

    assign x_s = CORDIC_W'($signed({i_center_x, {CORDIC_FRAC{1'b0}}}));
    assign y_s = CORDIC_W'($signed({i_center_y, {CORDIC_FRAC{1'b0}}}));
    assign x0  = i_center_x[POS_W-1] ? -x_s : x_s;
    assign y0  = i_center_x[POS_W-1] ? -y_s : y_s;
    assign z0  = i_center_x[POS_W-1] ? {1'b1, {(Z_W-1){1'b0}}} : '0;
    assign mag = i_spin_rate[15] ? (~i_spin_rate + 16'd1) : i_spin_rate;

    always_comb begin
        if (i_plate_count == 4'd0) begin
            plates = PLATE_W'(1);
        end else if (int'(i_plate_count) > MAX_PLATES) begin
            plates = PLATE_W'(MAX_PLATES);
        end else begin
            plates = PLATE_W'(i_plate_count);
        end
        side.head     = scale16(i_spin_heading);
        side.plates   = plates;
        side.lead_en  = !(mag < {1'b0, i_min_rate});
        side.lead_neg = !(!i_spin_rate[15] && (i_spin_rate != 16'sd0));
        side.origin   = (i_center_x == '0) && (i_center_y == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x    <= x0;
            r_y    <= y0;
            r_z    <= z0;
            r_side <= side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

// File: hw/rtl/stps_cordic.sv
// Vectoring CORDIC, one micro-rotation per register stage, sideband carried along.
// Depends on stps_pkg; fed by stps_front, feeds stps_back.
module stps_cordic (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic                                 i_valid,
    input  logic signed [stps_pkg::CORDIC_W-1:0] i_x,
    input  logic signed [stps_pkg::CORDIC_W-1:0] i_y,
    input  logic [stps_pkg::Z_W-1:0]             i_z,
    input  stps_pkg::t_side                      i_side,
    output logic                                 o_valid,
    output logic [stps_pkg::Z_W-1:0]             o_z,
    output stps_pkg::t_side                      o_side
);
    import stps_pkg::*;

    localparam int LAST = CORDIC_STEPS - 1;

    logic signed [CORDIC_W-1:0] r_x [0:LAST-1];
    logic signed [CORDIC_W-1:0] r_y [0:LAST-1];
    logic [Z_W-1:0]             r_z [0:LAST];
    t_side                      r_s [0:LAST];
    logic                       r_v [0:LAST];

    logic signed [CORDIC_W-1:0] n_x [0:LAST-1];
    logic signed [CORDIC_W-1:0] n_y [0:LAST-1];
    logic [Z_W-1:0]             n_z [0:LAST];
    t_side                      n_s [0:LAST];
    logic                       n_v [0:LAST];

    always_comb begin
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            logic signed [CORDIC_W-1:0] xi, yi;
            logic [Z_W-1:0]             zi;
            if (k == 0) begin
                xi     = i_x;
                yi     = i_y;
                zi     = i_z;
                n_s[k] = i_side;
                n_v[k] = i_valid;
            end else begin
                xi     = r_x[k-1];
                yi     = r_y[k-1];
                zi     = r_z[k-1];
                n_s[k] = r_s[k-1];
                n_v[k] = r_v[k-1];
            end
            if (!yi[CORDIC_W-1]) begin
                n_z[k] = zi + atan_step(k);
                if (k < LAST) begin
                    n_x[k] = xi + (yi >>> k);
                    n_y[k] = yi - (xi >>> k);
                end
            end else begin
                n_z[k] = zi - atan_step(k);
                if (k < LAST) begin
                    n_x[k] = xi - (yi >>> k);
                    n_y[k] = yi + (xi >>> k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_adv) begin
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_v[k] <= n_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_z[k] <= n_z[k];
                r_s[k] <= n_s[k];
            end
            for (int k = 0; k < LAST; k++) begin
                r_x[k] <= n_x[k];
                r_y[k] <= n_y[k];
            end
        end
    end

    assign o_valid = r_v[LAST];
    assign o_z     = r_z[LAST];
    assign o_side  = r_s[LAST];

endmodule

// File: hw/rtl/stps_back.sv
// Back end: bearing rounding, decision angle fold, lead and sector offset, quantizer.
// Depends on stps_pkg; fed by stps_cordic, feeds the output stage of the top level.
module stps_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic [stps_pkg::Z_W-1:0]      i_z,
    input  stps_pkg::t_side               i_side,
    input  logic [stps_pkg::JUMP_W-1:0]   i_jump,
    output logic                          o_valid,
    output logic [2:0]                    o_plate_index
);
    import stps_pkg::*;

    localparam int AB = ANGLE_BITS;
    localparam int PW = AB + 1 + PLATE_W;
    localparam logic [Z_W-1:0]   ROUND   = Z_W'(1) << (Z_W - 1 - AB);
    localparam logic signed [AB:0]   QUARTER = (AB+1)'(1) <<< (AB - 2);
    localparam logic signed [AB:0]   HALF    = (AB+1)'(1) <<< (AB - 1);
    localparam logic signed [AB+1:0] TURN    = (AB+2)'(1) <<< AB;

    logic [AB-1:0] half_sec [1:MAX_PLATES];

    for (genvar g = 1; g <= MAX_PLATES; g++) begin : g_hs
        localparam int unsigned HS = (1 << AB) / (2 * g);
        assign half_sec[g] = AB'(HS);
    end

    logic [Z_W-1:0]        zs;
    logic [AB-1:0]         d;
    logic signed [AB:0]    de, f;
    logic signed [AB+1:0]  je, th, tmp, tw;
    logic [PW-1:0]         prod;
    logic [PLATE_W:0]      idx;
    logic [PLATE_W-1:0]    lim, sel;

    logic                  r_b1_v, r_b2_v, r_b3_v;
    logic [AB-1:0]         r_b1_alpha;
    t_side                 r_b1_side, r_b2_side;
    logic signed [AB:0]    r_b2_f;
    logic [AB:0]           r_b3_t;
    logic [PLATE_W-1:0]    r_b3_plates;

    assign zs = i_z + ROUND;
    assign d  = r_b1_side.head - r_b1_alpha;
    assign de = $signed({d[AB-1], d});

    always_comb begin
        if (de > QUARTER) begin
            f = HALF - de;
        end else if (de < -QUARTER) begin
            f = -HALF - de;
        end else begin
            f = de;
        end
    end

    assign je = $signed({2'b00, scale16({2'b00, i_jump})});

    always_comb begin
        if (!r_b2_side.lead_en) begin
            th = '0;
        end else if (r_b2_side.lead_neg) begin
            th = -je;
        end else begin
            th = je;
        end
        tmp = $signed({2'b00, half_sec[r_b2_side.plates]}) - (AB+2)'(r_b2_f) - th;
        tw  = tmp[AB+1] ? (tmp + TURN) : tmp;
    end

    assign prod = PW'(r_b3_t) * PW'(r_b3_plates);
    assign idx  = prod[PW-1:AB];
    assign lim  = r_b3_plates - PLATE_W'(1);
    assign sel  = (idx > {1'b0, lim}) ? lim : idx[PLATE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
            r_b3_v <= 1'b0;
        end else if (i_adv) begin
            r_b1_v <= i_valid;
            r_b2_v <= r_b1_v;
            r_b3_v <= r_b2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b1_alpha  <= i_side.origin ? '0 : zs[Z_W-1 -: AB];
            r_b1_side   <= i_side;
            r_b2_f      <= f;
            r_b2_side   <= r_b1_side;
            r_b3_t      <= tw[AB:0];
            r_b3_plates <= r_b2_side.plates;
        end
    end

    assign o_valid       = r_b3_v;
    assign o_plate_index = 3'(sel);

    a_plates_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b1_v |-> (r_b1_side.plates != '0) && (int'(r_b1_side.plates) <= MAX_PLATES))
        else $error("plate count outside clamp range");

    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b2_v |-> (r_b2_f <= QUARTER) && (r_b2_f >= -QUARTER))
        else $error("decision angle beyond a quarter turn");

    a_sum_below_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b3_v |-> !r_b3_t[AB])
        else $error("wrapped angle sum reached a full turn");

endmodule

// File: hw/rtl/spinning_target_plate_selector.sv
// Top level of the spinning target plate selector: register port, pipeline, output stage.
// Depends on stps_pkg, stps_front, stps_cordic and stps_back.
//
// One item enters per clock while o_stall is low; its plate index is presented once the
// item has passed 36 register stages in all, one input stage, 31 CORDIC stages (one
// micro-rotation each, this chain sets the latency), three back-end stages and the
// output register. The output has a register plus a one-entry skid; o_stall is the
// registered skid flag, set when a result meets a stalled output, and the pipeline
// freezes only while the skid holds an item. jump_angle sits at address 0 and
// min_switch_rate at address 4; write them while no item is in flight.
module spinning_target_plate_selector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [stps_pkg::POS_W-1:0] i_center_x,
    input  logic signed [stps_pkg::POS_W-1:0] i_center_y,
    input  logic [15:0]                       i_spin_heading,
    input  logic signed [15:0]                i_spin_rate,
    input  logic [3:0]                        i_plate_count,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [2:0]                        o_plate_index,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import stps_pkg::*;

    localparam logic REG_JUMP_ANGLE = 1'b0;
    localparam logic REG_MIN_RATE   = 1'b1;

    logic [JUMP_W-1:0] r_jump;
    logic [RATE_W-1:0] r_min_rate;

    logic                       adv, out_take, cfg_wr;
    logic                       f_valid, c_valid, b_valid;
    logic signed [CORDIC_W-1:0] f_x, f_y;
    logic [Z_W-1:0]             f_z, c_z;
    t_side                      f_side, c_side;
    logic [2:0]                 b_idx;

    logic       r_out_v, r_skid_v;
    logic [2:0] r_out_idx, r_skid_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump     <= JUMP_W'(2731);
            r_min_rate <= RATE_W'(256);
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_JUMP_ANGLE: r_jump     <= pwdata[JUMP_W-1:0];
                REG_MIN_RATE:   r_min_rate <= pwdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_JUMP_ANGLE: prdata = {{(32-JUMP_W){1'b0}}, r_jump};
            REG_MIN_RATE:   prdata = {{(32-RATE_W){1'b0}}, r_min_rate};
            default:        prdata = '0;
        endcase
    end

    assign adv      = !r_skid_v;
    assign o_stall  = r_skid_v;
    assign out_take = !r_out_v || !i_stall;

    stps_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_valid        (i_valid),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_spin_heading (i_spin_heading),
        .i_spin_rate    (i_spin_rate),
        .i_plate_count  (i_plate_count),
        .i_min_rate     (r_min_rate),
        .o_valid        (f_valid),
        .o_x            (f_x),
        .o_y            (f_y),
        .o_z            (f_z),
        .o_side         (f_side)
    );

    stps_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (f_valid),
        .i_x     (f_x),
        .i_y     (f_y),
        .i_z     (f_z),
        .i_side  (f_side),
        .o_valid (c_valid),
        .o_z     (c_z),
        .o_side  (c_side)
    );

    stps_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_valid       (c_valid),
        .i_z           (c_z),
        .i_side        (c_side),
        .i_jump        (r_jump),
        .o_valid       (b_valid),
        .o_plate_index (b_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (out_take) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (out_take) begin
            r_out_v <= b_valid;
        end else if (b_valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (out_take) begin
                r_out_idx <= r_skid_idx;
            end
        end else if (out_take) begin
            if (b_valid) begin
                r_out_idx <= b_idx;
            end
        end else if (b_valid) begin
            r_skid_idx <= b_idx;
        end
    end

    assign o_valid       = r_out_v;
    assign o_plate_index = r_out_idx;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds an item while the output register is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && !i_stall |=> !r_skid_v && r_out_v)
        else $error("skid item not moved to the output register");

    a_skid_catches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_skid_v && r_out_v && i_stall && b_valid |=> r_skid_v && $stable(r_out_idx))
        else $error("result lost while the output was stalled");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for spinning_target_plate_selector: streams target items,
// predicts each plate index with its own CORDIC bearing and angle fold, compares results.
// Depends on stps_pkg and the RTL of the block; reads no files.

module testbench;

    localparam int ANGLE_W     = stps_pkg::ANGLE_BITS;
    localparam int PLATES_MAX  = stps_pkg::MAX_PLATES;
    localparam int POS_FRAC    = 30;
    localparam logic [2:0] JUMP_ANGLE_ADDR      = 3'd0;
    localparam logic [2:0] MIN_SWITCH_RATE_ADDR = 3'd4;
    localparam int PIPE_SETTLE = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 5000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic signed [23:0]      i_center_x = '0;
    logic signed [23:0]      i_center_y = '0;
    logic [15:0]             i_spin_heading = '0;
    logic signed [15:0]      i_spin_rate = '0;
    logic [3:0]              i_plate_count = 4'd1;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [2:0]              o_plate_index;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [2:0]              paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;

    logic [13:0]             jump_setting = 14'd2731;
    logic [14:0]             min_rate_setting = 15'd256;
    logic [2:0]              plate_index_q [$];
    logic [2:0]              want_index;
    logic                    hold_output = 1'b0;
    event                    hold_request;
    int                      send_idle_pct = 0;
    int                      stall_pct = 0;
    int                      errors = 0;
    int                      items_accepted = 0;
    int                      results_checked = 0;
    int                      input_holdoff_cycles = 0;
    int                      settings_loaded = 1;
    int                      quiet_cycles = 0;

    int unsigned atan_turns [31] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1
    };

    spinning_target_plate_selector DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_spin_heading (i_spin_heading),
        .i_spin_rate    (i_spin_rate),
        .i_plate_count  (i_plate_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_plate_index  (o_plate_index),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint angle_from16(input longint v);
        if (ANGLE_W >= 16) return v <<< (ANGLE_W - 16);
        return v >>> (16 - ANGLE_W);
    endfunction

    function automatic longint centre_bearing(input longint cx, input longint cy);
        longint      x, y, dx, dy;
        logic [31:0] z, r;
        if (cx == 0 && cy == 0) return 0;
        x = cx <<< POS_FRAC;
        y = cy <<< POS_FRAC;
        z = '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < 31; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx;
                y -= dy;
                z += atan_turns[i];
            end else begin
                x -= dx;
                y += dy;
                z -= atan_turns[i];
            end
        end
        r = (z + (32'd1 << (31 - ANGLE_W))) >> (32 - ANGLE_W);
        return longint'(r);
    endfunction

    function automatic logic [2:0] predict_plate(input logic signed [23:0] cx,
                                                 input logic signed [23:0] cy,
                                                 input logic [15:0] hd,
                                                 input logic signed [15:0] rt,
                                                 input logic [3:0] pc);
        longint turn, n, d, f, mag, theta, sum, idx;
        turn = 64'sd1 <<< ANGLE_W;
        n = longint'(pc);
        if (n < 1) n = 1;
        if (n > PLATES_MAX) n = PLATES_MAX;
        d = (angle_from16(longint'(hd)) - centre_bearing(cx, cy)) & (turn - 1);
        if (d >= turn / 2) d -= turn;
        if (d > turn / 4) f = turn / 2 - d;
        else if (d < -(turn / 4)) f = -(turn / 2) - d;
        else f = d;
        mag = longint'(rt);
        if (mag < 0) mag = -mag;
        if (mag < longint'(min_rate_setting)) theta = 0;
        else if (rt > 0) theta = angle_from16(longint'(jump_setting));
        else theta = -angle_from16(longint'(jump_setting));
        sum = -f + turn / (2 * n) - theta;
        if (sum < 0) sum += turn;
        if (sum < 0) sum = 0;
        idx = (sum * n) >>> ANGLE_W;
        if (idx > n - 1) idx = n - 1;
        return 3'(idx);
    endfunction

    always @(posedge i_clk) begin
        i_stall <= hold_output || ($urandom_range(99) < stall_pct);
    end

    always begin
        @(hold_request);
        hold_output <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_output <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_checked++;
                if (plate_index_q.size() == 0) begin
                    $display("%0t: plate index: expected none, got %0d", $time, o_plate_index);
                    errors++;
                end else begin
                    want_index = plate_index_q.pop_front();
                    if (o_plate_index !== want_index) begin
                        $display("%0t: plate index: expected %0d, got %0d",
                                 $time, want_index, o_plate_index);
                        errors++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                plate_index_q.push_back(predict_plate(i_center_x, i_center_y, i_spin_heading,
                                                      i_spin_rate, i_plate_count));
                items_accepted++;
            end
            if (i_valid && o_stall) input_holdoff_cycles++;
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic register_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic verify_register(input logic [2:0] addr, input logic [31:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $display("%0t: register at %0d: expected %0d, got %0d", $time, addr, want, prdata);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_target(input logic signed [23:0] cx, input logic signed [23:0] cy,
                               input logic [15:0] hd, input logic signed [15:0] rt,
                               input logic [3:0] pc);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_center_x <= cx;
        i_center_y <= cy;
        i_spin_heading <= hd;
        i_spin_rate <= rt;
        i_plate_count <= pc;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_random_target();
        logic signed [23:0] pos [2];
        logic [15:0]        hd;
        logic signed [15:0] rt;
        logic [3:0]         pc;
        for (int k = 0; k < 2; k++) begin
            case ($urandom_range(4))
                0, 1: pos[k] = 24'($urandom);
                2: pos[k] = 24'($urandom_range(512)) - 24'd256;
                3: pos[k] = '0;
                default: pos[k] = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            endcase
        end
        if ($urandom_range(3) == 0) hd = 16'($urandom_range(3) * 16384 + $urandom_range(4)) - 16'd2;
        else hd = 16'($urandom);
        case ($urandom_range(3))
            0: rt = 16'($urandom);
            1: begin
                rt = 16'(min_rate_setting) + 16'($urandom_range(4)) - 16'd2;
                if ($urandom_range(1)) rt = -rt;
            end
            2: rt = '0;
            default: rt = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        endcase
        pc = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8, 1));
        send_target(pos[0], pos[1], hd, rt, pc);
    endtask

    task automatic drain_pipeline();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (plate_index_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic load_lead_settings(input logic [13:0] jump, input logic [14:0] min_rate);
        drain_pipeline();
        register_write(JUMP_ANGLE_ADDR, {18'd0, jump});
        register_write(MIN_SWITCH_RATE_ADDR, {17'd0, min_rate});
        jump_setting = jump;
        min_rate_setting = min_rate;
        verify_register(JUMP_ANGLE_ADDR, {18'd0, jump_setting});
        verify_register(MIN_SWITCH_RATE_ADDR, {17'd0, min_rate_setting});
        settings_loaded++;
    endtask

    task automatic test_register_access();
        verify_register(JUMP_ANGLE_ADDR, {18'd0, jump_setting});
        verify_register(MIN_SWITCH_RATE_ADDR, {17'd0, min_rate_setting});
    endtask

    task automatic test_corner_targets();
        send_idle_pct = 0;
        stall_pct = 0;
        send_target(24'd0, 24'd0, 16'd0, 16'sd0, 4'd1);
        send_target(24'd0, 24'd0, 16'd0, 16'sd300, 4'd8);
        send_target(24'd0, 24'd0, 16'd0, -16'sd300, 4'd8);
        send_target(24'd0, 24'd0, 16'd16384, 16'sd256, 4'd4);
        send_target(24'd0, 24'd0, 16'd16384, -16'sd255, 4'd4);
        send_target(24'd0, 24'd0, 16'd0, -16'sd256, 4'd8);
        send_target(24'h800000, 24'd0, 16'd0, 16'h7FFF, 4'd8);
        send_target(24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 16'h8000, 4'd3);
        send_target(24'd0, 24'h800000, 16'd49152, 16'sd0, 4'd5);
        send_target(24'd0, 24'h7FFFFF, 16'd16384, 16'sd1000, 4'd6);
        send_target(24'h800000, 24'h800000, 16'd32768, -16'sd1000, 4'd7);
        send_target(24'h7FFFFF, 24'hFFFFFF, 16'd16385, 16'sd0, 4'd2);
        send_target(24'd4096, 24'd0, 16'd49151, 16'sd0, 4'd2);
        send_target(24'hFFFFFF, 24'd1, 16'd32767, 16'sd500, 4'd0);
        send_target(24'd1, 24'hFFFFFF, 16'd12345, 16'sd500, 4'd9);
        send_target(24'd100, 24'd200, 16'd0, 16'sd256, 4'd15);
        send_target(24'h7FFFFF, 24'd0, 16'd0, 16'h8000, 4'd8);
        send_target(24'd4096, 24'd0, 16'd8000, 16'sd300, 4'd8);
        send_target(24'd4096, 24'd0, 16'd49152, -16'sd300, 4'd1);
        send_target(24'd0, 24'd0, 16'hFFFF, 16'h8000, 4'd8);
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct, input int hold_pct);
        send_idle_pct = idle_pct;
        stall_pct = hold_pct;
        repeat (count) send_random_target();
    endtask

    task automatic test_output_backpressure(input int count);
        send_idle_pct = 0;
        stall_pct = 0;
        -> hold_request;
        repeat (count) send_random_target();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_access();
        test_corner_targets();
        test_random_traffic(80, 0, 0);
        load_lead_settings(14'd16383, 15'd0);
        test_random_traffic(70, 71, 0);
        load_lead_settings(14'd0, 15'd32767);
        test_random_traffic(60, 0, 71);
        load_lead_settings(14'($urandom), 15'($urandom));
        test_random_traffic(70, 38, 38);
        load_lead_settings(14'd16383, 15'd32767);
        test_output_backpressure(60);
        load_lead_settings(14'd2731, 15'd256);
        test_random_traffic(60, 38, 38);
        drain_pipeline();
        $display("Run covered %0d items and %0d checked plate indexes over %0d lead settings,",
                 items_accepted, results_checked, settings_loaded);
        $display("with the input held off for %0d cycles by output back-pressure.",
                 input_holdoff_cycles);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/stps_pkg.sv
hw/rtl/stps_front.sv
hw/rtl/stps_cordic.sv
hw/rtl/stps_back.sv
hw/rtl/spinning_target_plate_selector.sv
tb/sv/testbench.sv
